// ----- design/music_sequence_command_decoder_assert.svh -----
// Assertion macros shared by the sequence command decoder RTL.
// Each macro builds one labeled concurrent assertion clocked on clk and
// disabled while the asynchronous reset rst_n is low.
`ifndef MUSIC_SEQUENCE_COMMAND_DECODER_ASSERT_SVH
`define MUSIC_SEQUENCE_COMMAND_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define MSCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- design/mscd_pkg.sv -----
// Types and constants for the sequence command decoder.
// Holds the transfer payload structs, event codes, opcodes and parse phases.
// Has no dependencies.
package mscd_pkg;

    typedef struct packed {
        logic [7:0] seq_byte;
        logic       channel_start;
    } seq_item_t;

    typedef struct packed {
        logic [3:0]  event_kind;
        logic [7:0]  value_a;
        logic [3:0]  value_b;
        logic [15:0] target_address;
        logic        channel_done;
    } event_item_t;

    typedef enum logic [3:0] {
        PH_OPCODE  = 4'b0001,
        PH_ARG     = 4'b0010,
        PH_ADDR_LO = 4'b0100,
        PH_ADDR_HI = 4'b1000
    } phase_t;

    localparam logic [3:0] EV_TEMPO   = 4'd0;
    localparam logic [3:0] EV_DUTY    = 4'd1;
    localparam logic [3:0] EV_VOLUME  = 4'd2;
    localparam logic [3:0] EV_LOOP    = 4'd3;
    localparam logic [3:0] EV_PAN     = 4'd4;
    localparam logic [3:0] EV_RETURN  = 4'd5;
    localparam logic [3:0] EV_STOP    = 4'd6;
    localparam logic [3:0] EV_JUMP    = 4'd7;
    localparam logic [3:0] EV_END     = 4'd8;
    localparam logic [3:0] EV_DISABLE = 4'd9;
    localparam logic [3:0] EV_HOLD    = 4'd10;
    localparam logic [3:0] EV_REST    = 4'd11;
    localparam logic [3:0] EV_OCTAVE  = 4'd12;
    localparam logic [3:0] EV_NOTE    = 4'd13;
    localparam logic [3:0] EV_UNKNOWN = 4'd14;

    localparam logic [7:0] OP_TEMPO   = 8'hC0;
    localparam logic [7:0] OP_DUTY    = 8'hC1;
    localparam logic [7:0] OP_VOLUME  = 8'hC2;
    localparam logic [7:0] OP_LOOP    = 8'hC3;
    localparam logic [7:0] OP_PAN     = 8'hC4;
    localparam logic [7:0] OP_RETURN  = 8'hC9;
    localparam logic [7:0] OP_STOP    = 8'hCB;
    localparam logic [7:0] OP_JUMP    = 8'hCD;
    localparam logic [7:0] OP_END     = 8'hCE;
    localparam logic [7:0] OP_DISABLE = 8'hCF;

    localparam logic [3:0] NIB_COMMAND = 4'hC;
    localparam logic [3:0] NIB_HOLD    = 4'hD;
    localparam logic [3:0] NIB_REST    = 4'hE;
    localparam logic [3:0] NIB_OCTAVE  = 4'hF;

endpackage

// ----- design/music_sequence_command_decoder.sv -----
// Top level of the sequence command decoder for one sound channel.
// Depends on mscd_pkg and on music_sequence_command_decoder_assert.svh.
// Turns a stream of sequence bytes into one decoded event per completed command.

// The decoder takes one sequence byte per clock cycle and can keep doing so
// without a gap: a byte is held in an input register and is decoded against
// the parse state. If the byte completes a command, its event is loaded into
// the output register when the input register advances, and it transfers out
// from there. Opcode bytes of commands that take arguments, low address
// bytes and bytes received after reset or a channel end give no event. A
// byte with channel_start set drops any partly received command and is
// decoded as a fresh opcode. Throughput drops below one byte per cycle only
// while the output side stalls with an event waiting.
`include "music_sequence_command_decoder_assert.svh"

module music_sequence_command_decoder
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       seq_valid,
    output logic                       seq_stall,
    input  mscd_pkg::seq_item_t        seq_item,
    output logic                       event_valid,
    input  logic                       event_stall,
    output mscd_pkg::event_item_t      event_item
);

    logic                   s1_valid_reg;
    mscd_pkg::seq_item_t    s1_item_reg;
    mscd_pkg::phase_t       phase_reg;
    mscd_pkg::phase_t       phase_next;
    logic [7:0]             held_reg;
    logic [7:0]             held_next;
    logic [7:0]             addr_lo_reg;
    logic [7:0]             addr_lo_next;
    logic                   ended_reg;
    logic                   ended_next;
    logic                   event_valid_reg;
    mscd_pkg::event_item_t  event_item_reg;

    logic                   out_free;
    logic                   s1_adv;
    mscd_pkg::phase_t       phase_eff;
    logic                   ended_eff;
    logic                   emit;
    mscd_pkg::event_item_t  res;
    logic [7:0]             b;

    assign out_free    = !event_valid_reg || !event_stall;
    assign s1_adv      = s1_valid_reg && out_free;
    assign seq_stall   = s1_valid_reg && !out_free;
    assign event_valid = event_valid_reg;
    assign event_item  = event_item_reg;
    assign b           = s1_item_reg.seq_byte;

    always_comb
    begin
        phase_eff    = s1_item_reg.channel_start ? mscd_pkg::PH_OPCODE : phase_reg;
        ended_eff    = s1_item_reg.channel_start ? 1'b0 : ended_reg;
        phase_next   = phase_eff;
        held_next    = held_reg;
        addr_lo_next = addr_lo_reg;
        emit         = 1'b0;
        res          = '0;
        if (!ended_eff)
        begin
            unique case (phase_eff)
                mscd_pkg::PH_ARG:
                begin
                    phase_next = mscd_pkg::PH_OPCODE;
                    emit       = 1'b1;
                    res.value_a = b;
                    if (held_reg == mscd_pkg::OP_TEMPO)
                    begin
                        res.event_kind = mscd_pkg::EV_TEMPO;
                    end
                    else if (held_reg == mscd_pkg::OP_DUTY)
                    begin
                        res.event_kind = mscd_pkg::EV_DUTY;
                    end
                    else if (held_reg == mscd_pkg::OP_VOLUME)
                    begin
                        res.event_kind = mscd_pkg::EV_VOLUME;
                        res.value_a    = {4'h0, b[7:4]};
                        res.value_b    = b[3:0];
                    end
                    else
                    begin
                        res.event_kind = mscd_pkg::EV_PAN;
                    end
                end
                mscd_pkg::PH_ADDR_LO:
                begin
                    addr_lo_next = b;
                    phase_next   = mscd_pkg::PH_ADDR_HI;
                end
                mscd_pkg::PH_ADDR_HI:
                begin
                    phase_next         = mscd_pkg::PH_OPCODE;
                    emit               = 1'b1;
                    res.target_address = {b, addr_lo_reg};
                    if (held_reg == mscd_pkg::OP_LOOP)
                    begin
                        res.event_kind   = mscd_pkg::EV_LOOP;
                        res.channel_done = 1'b1;
                    end
                    else
                    begin
                        res.event_kind = mscd_pkg::EV_JUMP;
                    end
                end
                mscd_pkg::PH_OPCODE:
                begin
                    unique case (b[7:4])
                        mscd_pkg::NIB_OCTAVE:
                        begin
                            emit           = 1'b1;
                            res.event_kind = mscd_pkg::EV_OCTAVE;
                            res.value_a    = {4'h0, b[3:0]};
                        end
                        mscd_pkg::NIB_REST:
                        begin
                            emit           = 1'b1;
                            res.event_kind = mscd_pkg::EV_REST;
                            res.value_a    = {4'h0, b[3:0]};
                        end
                        mscd_pkg::NIB_HOLD:
                        begin
                            emit           = 1'b1;
                            res.event_kind = mscd_pkg::EV_HOLD;
                            res.value_a    = {4'h0, b[3:0]};
                        end
                        mscd_pkg::NIB_COMMAND:
                        begin
                            unique case (b) inside
                                mscd_pkg::OP_TEMPO, mscd_pkg::OP_DUTY,
                                mscd_pkg::OP_VOLUME, mscd_pkg::OP_PAN:
                                begin
                                    held_next  = b;
                                    phase_next = mscd_pkg::PH_ARG;
                                end
                                mscd_pkg::OP_LOOP, mscd_pkg::OP_JUMP:
                                begin
                                    held_next  = b;
                                    phase_next = mscd_pkg::PH_ADDR_LO;
                                end
                                mscd_pkg::OP_RETURN:
                                begin
                                    emit           = 1'b1;
                                    res.event_kind = mscd_pkg::EV_RETURN;
                                end
                                mscd_pkg::OP_STOP:
                                begin
                                    emit             = 1'b1;
                                    res.event_kind   = mscd_pkg::EV_STOP;
                                    res.channel_done = 1'b1;
                                end
                                mscd_pkg::OP_END:
                                begin
                                    emit             = 1'b1;
                                    res.event_kind   = mscd_pkg::EV_END;
                                    res.channel_done = 1'b1;
                                end
                                mscd_pkg::OP_DISABLE:
                                begin
                                    emit             = 1'b1;
                                    res.event_kind   = mscd_pkg::EV_DISABLE;
                                    res.channel_done = 1'b1;
                                end
                                default:
                                begin
                                    emit           = 1'b1;
                                    res.event_kind = mscd_pkg::EV_UNKNOWN;
                                    res.value_a    = b;
                                end
                            endcase
                        end
                        default:
                        begin
                            emit           = 1'b1;
                            res.event_kind = mscd_pkg::EV_NOTE;
                            res.value_a    = {4'h0, b[7:4]};
                            res.value_b    = b[3:0];
                        end
                    endcase
                end
                default:
                begin
                    phase_next = mscd_pkg::PH_OPCODE;
                end
            endcase
        end
        ended_next = ended_eff || (emit && res.channel_done);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            phase_reg       <= mscd_pkg::PH_OPCODE;
            held_reg        <= '0;
            addr_lo_reg     <= '0;
            ended_reg       <= 1'b1;
            event_valid_reg <= 1'b0;
        end
        else
        begin
            if (!s1_valid_reg || s1_adv)
            begin
                s1_valid_reg <= seq_valid;
            end
            if (s1_adv)
            begin
                phase_reg       <= phase_next;
                held_reg        <= held_next;
                addr_lo_reg     <= addr_lo_next;
                ended_reg       <= ended_next;
                event_valid_reg <= emit;
            end
            else if (!event_stall)
            begin
                event_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!s1_valid_reg || s1_adv)
        begin
            s1_item_reg <= seq_item;
        end
        if (s1_adv && emit)
        begin
            event_item_reg <= res;
        end
    end

    `MSCD_ASSERT_SAME(a_ended_phase_idle, ended_reg, phase_reg == mscd_pkg::PH_OPCODE)
    `MSCD_ASSERT_NEXT(a_done_sets_ended, s1_adv && emit && res.channel_done, ended_reg)
    `MSCD_ASSERT_NEXT(a_addr_hi_emits, s1_adv && !ended_eff && phase_eff == mscd_pkg::PH_ADDR_HI, event_valid_reg)

endmodule
